[rtl/errl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// errl_pkg
// Shared types, codes and helpers of the entropy record/replay log.
// ----------------------------------------------------------------------------
package errl_pkg;

   localparam int LOG_DEPTH  = 4096;
   localparam int LOG_AW     = $clog2(LOG_DEPTH);
   localparam int CNT_W      = LOG_AW + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = CNT_W;

   // item opcodes
   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_EPOCH = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // entropy modes (the unused code behaves as off)
   localparam logic [1:0] EM_OFF    = 2'd0;
   localparam logic [1:0] EM_RECORD = 2'd1;
   localparam logic [1:0] EM_REPLAY = 2'd2;

   // result status
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_SRC_ERR   = 2'd1;
   localparam logic [1:0] STAT_LOAD_FULL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENTROPY_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY     = 2'd1;

   typedef struct packed {
      logic [1:0]        mode;
      logic [7:0]        data_byte;
      logic              live_ok;
      logic [63:0]       epoch_value;
      logic [LOG_AW-1:0] entry_index;
      logic              last_byte;
   } errl_req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic [1:0]       status;
      logic [CNT_W-1:0] stored_count;
      logic [31:0]      overflow_total;
      logic [31:0]      underflow_total;
      logic [63:0]      epoch_out;
      logic             last_marker;
   } errl_rsp_type;

   typedef struct packed {
      logic [1:0]       entropy_mode;
      logic [CNT_W-1:0] capacity_limit;
   } errl_cfg_type;

   typedef struct packed {
      logic              en;
      logic [LOG_AW-1:0] addr;
      logic [7:0]        data;
   } errl_wr_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage
`default_nettype wire

[rtl/errl_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// errl_if
// Valid/ready channels of the entropy record/replay log.
// ----------------------------------------------------------------------------
interface errl_req_if;
   logic                  valid;
   logic                  ready;
   errl_pkg::errl_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface errl_rsp_if;
   logic                  valid;
   logic                  ready;
   errl_pkg::errl_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/errl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// errl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module errl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[rtl/errl_exec.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// errl_exec
// Log bookkeeping: counts, replay cursor, epoch, and the result of one item.
// ----------------------------------------------------------------------------
module errl_exec (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire errl_pkg::errl_cfg_type cfg,
   input  wire errl_pkg::errl_req_type item,
   input  wire logic                   commit,
   input  wire logic [7:0]             rd_data,
   output errl_pkg::errl_rsp_type      result,
   output errl_pkg::errl_wr_type       wr,
   output logic [errl_pkg::CNT_W-1:0]  cursor
);

   logic [errl_pkg::CNT_W-1:0] wcount_ff, wcount_in;
   logic [errl_pkg::CNT_W-1:0] cursor_ff, cursor_in;
   logic [31:0]                ovf_ff, ovf_in;
   logic [31:0]                udf_ff, udf_in;
   logic [63:0]                epoch_ff, epoch_in;
   logic                       load_open_ff, load_open_in;
   logic [errl_pkg::CNT_W-1:0] cap_eff;
   logic [errl_pkg::CNT_W-1:0] base_wc;
   logic [7:0]                 out_byte;
   logic [1:0]                 status;

   // clamp capacity into 1..LOG_DEPTH
   always_comb begin
      cap_eff = cfg.capacity_limit;
      if (cfg.capacity_limit == '0) begin
         cap_eff = errl_pkg::CNT_W'(1);
      end else if (cfg.capacity_limit > errl_pkg::CNT_W'(errl_pkg::LOG_DEPTH)) begin
         cap_eff = errl_pkg::CNT_W'(errl_pkg::LOG_DEPTH);
      end
   end

   always_comb begin
      wcount_in    = wcount_ff;
      cursor_in    = cursor_ff;
      ovf_in       = ovf_ff;
      udf_in       = udf_ff;
      epoch_in     = epoch_ff;
      load_open_in = 1'b0;
      out_byte     = 8'd0;
      status       = errl_pkg::STAT_OK;
      wr.en        = 1'b0;
      wr.addr      = wcount_ff[errl_pkg::LOG_AW-1:0];
      wr.data      = item.data_byte;
      base_wc      = load_open_ff ? wcount_ff : '0;
      unique case (item.mode)
         errl_pkg::OP_DRAW: begin
            if (cfg.entropy_mode == errl_pkg::EM_REPLAY) begin
               if (cursor_ff < wcount_ff) begin
                  out_byte  = rd_data;
                  cursor_in = cursor_ff + errl_pkg::CNT_W'(1);
               end else begin
                  udf_in = errl_pkg::sat_inc(udf_ff);
               end
            end else if (!item.live_ok) begin
               status = errl_pkg::STAT_SRC_ERR;
            end else begin
               out_byte = item.data_byte;
               if (cfg.entropy_mode == errl_pkg::EM_RECORD) begin
                  if (wcount_ff < cap_eff) begin
                     wr.en     = 1'b1;
                     wcount_in = wcount_ff + errl_pkg::CNT_W'(1);
                  end else begin
                     ovf_in = errl_pkg::sat_inc(ovf_ff);
                  end
               end
            end
         end
         errl_pkg::OP_EPOCH: begin
            epoch_in  = item.epoch_value;
            wcount_in = '0;
            cursor_in = '0;
            ovf_in    = 32'd0;
            udf_in    = 32'd0;
         end
         errl_pkg::OP_LOAD: begin
            // first byte of a load opens a fresh epoch
            if (!load_open_ff) begin
               epoch_in  = item.epoch_value;
               wcount_in = '0;
               cursor_in = '0;
               ovf_in    = 32'd0;
               udf_in    = 32'd0;
            end
            wr.addr = base_wc[errl_pkg::LOG_AW-1:0];
            if (base_wc < cap_eff) begin
               wr.en     = 1'b1;
               wcount_in = base_wc + errl_pkg::CNT_W'(1);
            end else begin
               status = errl_pkg::STAT_LOAD_FULL;
            end
            load_open_in = !item.last_byte;
         end
         errl_pkg::OP_READ: begin
            out_byte = rd_data;
         end
         default: begin
            out_byte = 8'd0;
         end
      endcase
      wr.en = wr.en & commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff    <= '0;
         cursor_ff    <= '0;
         ovf_ff       <= 32'd0;
         udf_ff       <= 32'd0;
         epoch_ff     <= 64'd0;
         load_open_ff <= 1'b0;
      end else if (commit) begin
         wcount_ff    <= wcount_in;
         cursor_ff    <= cursor_in;
         ovf_ff       <= ovf_in;
         udf_ff       <= udf_in;
         epoch_ff     <= epoch_in;
         load_open_ff <= load_open_in;
      end
   end

   assign result.out_byte        = out_byte;
   assign result.status          = status;
   assign result.stored_count    = wcount_in;
   assign result.overflow_total  = ovf_in;
   assign result.underflow_total = udf_in;
   assign result.epoch_out       = epoch_in;
   assign result.last_marker     = item.last_byte;
   assign cursor                 = cursor_ff;

endmodule
`default_nettype wire

[rtl/entropy_record_replay_log.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// entropy_record_replay_log
// Record/replay log for random bytes: pass, record, replay, load, read back.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            contents
//  req_if   in         valid/ready          one draw, epoch, load or read
//  rsp_if   out        valid/ready          one result per transaction
//  csr_*    in         csr_wr_en            entropy_mode, capacity_limit
//
//  An item issues the log read in its accept cycle, then in S_EXEC updates
//  the log and counters; the block takes no new item until that update,
//  as the log RAM returns its read data registered.
//  A result waits in the output register while the next item is accepted;
//  an item in S_EXEC holds there while that register stays full.
//  Reset is synchronous and clears all counters; the log needs no clearing.
// ----------------------------------------------------------------------------
module entropy_record_replay_log (
   input  wire logic                                clock,
   input  wire logic                                reset,
   errl_req_if.sink                                 req_if,
   errl_rsp_if.source                               rsp_if,
   input  wire logic                                csr_wr_en,
   input  wire logic [errl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [errl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                  state_ff, state_in;
   errl_pkg::errl_req_type     item_ff;
   errl_pkg::errl_rsp_type     rsp_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   errl_pkg::errl_cfg_type     cfg_ff, cfg_in;
   errl_pkg::errl_rsp_type     result;
   errl_pkg::errl_wr_type      wr;
   logic [errl_pkg::CNT_W-1:0] cursor;
   logic [errl_pkg::LOG_AW-1:0] rd_addr;
   logic [7:0]                 rd_data;
   logic                       accept;
   logic                       commit;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign commit       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_if.ready);

   // draws read at the replay cursor, read items at their own index
   assign rd_addr = (req_if.payload.mode == errl_pkg::OP_DRAW)
                  ? cursor[errl_pkg::LOG_AW-1:0] : req_if.payload.entry_index;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            errl_pkg::CSR_ENTROPY_MODE: cfg_in.entropy_mode   = csr_wdata[1:0];
            errl_pkg::CSR_CAPACITY:     cfg_in.capacity_limit = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= S_IDLE;
         rsp_valid_ff          <= 1'b0;
         cfg_ff.entropy_mode   <= errl_pkg::EM_OFF;
         cfg_ff.capacity_limit <= errl_pkg::CNT_W'(errl_pkg::LOG_DEPTH);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_if.payload;
      end
      if (commit) begin
         rsp_data_ff <= result;
      end
   end

   errl_ram #(
      .WIDTH (8),
      .DEPTH (errl_pkg::LOG_DEPTH)
   ) u_log (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   errl_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (item_ff),
      .commit  (commit),
      .rd_data (rd_data),
      .result  (result),
      .wr      (wr),
      .cursor  (cursor)
   );

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/errl_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// errl_chk
// Port-level checks of the entropy record/replay log, bound to the top level.
// ----------------------------------------------------------------------------
module errl_chk (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire errl_pkg::errl_rsp_type rsp_payload
);

   // no result may appear right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one transaction at a time: busy in the cycle after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   // a source error never carries a byte
   a_src_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == errl_pkg::STAT_SRC_ERR)
      |-> (rsp_payload.out_byte == 8'd0))
      else $error("source error with nonzero byte");

   // the log never reports more bytes than it holds
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.stored_count <= errl_pkg::CNT_W'(errl_pkg::LOG_DEPTH)))
      else $error("stored count beyond log depth");

endmodule

bind entropy_record_replay_log errl_chk u_errl_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
`default_nettype wire
